[src/failure_lockout_table_assert.svh]
// ----------------------------------------------------------------------------
// failure lockout table assertion macros
// shared property forms for the lockout table checks
// ----------------------------------------------------------------------------
`ifndef FAILURE_LOCKOUT_TABLE_ASSERT_SVH
`define FAILURE_LOCKOUT_TABLE_ASSERT_SVH

// same-cycle implication
`define LOT_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lockout table check failed");

// next-cycle implication
`define LOT_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lockout table check failed");

`endif

[src/lot_pkg.sv]
// ----------------------------------------------------------------------------
// lockout table package
// command codes, cell operations and the structs shared by cells and control
// ----------------------------------------------------------------------------
package lot_pkg;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_FAILURE = 3'd1;
    localparam logic [2:0] CMD_SUCCESS = 3'd2;
    localparam logic [2:0] CMD_BLOCK   = 3'd3;
    localparam logic [2:0] CMD_UNBLOCK = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;
    localparam logic [2:0] CMD_STATS   = 3'd6;
    localparam logic [2:0] CMD_CLEAR   = 3'd7;

    localparam logic [1:0] CFG_MAX_FAILURES   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_DURATION = 2'd1;
    localparam logic [1:0] CFG_FAILURE_WINDOW = 2'd2;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SWEEP,
        OP_FAIL_ADD,
        OP_FREE,
        OP_BLOCK,
        OP_COUNT,
        OP_CLEAR
    } lot_op_t;

    typedef struct packed {
        lot_op_t     op;
        logic        use_free;
        logic [31:0] key;
        logic [31:0] clock;
        logic [15:0] window;
        logic [15:0] length;
        logic [4:0]  limit;
    } lot_ctl_t;

    typedef struct packed {
        logic run;
        logic free_seen;
        logic match_seen;
    } lot_tok_t;

    typedef struct packed {
        logic        is_block;
        logic [31:0] start;
        logic [15:0] len;
        logic [4:0]  qcnt;
    } lot_rd_t;

endpackage

[src/lot_cell.sv]
// ----------------------------------------------------------------------------
// lockout table cell
// one table entry with its stamp history; passes the scan token onward
// ----------------------------------------------------------------------------
module lot_cell #(
    parameter int STAMPS = 16,
    parameter int CW     = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lot_pkg::lot_ctl_t ctl,
    input  lot_pkg::lot_tok_t tok_in,
    input  logic [CW-1:0]     act_in,
    input  logic [CW-1:0]     trk_in,
    output lot_pkg::lot_tok_t tok_out,
    output logic [CW-1:0]     act_out,
    output logic [CW-1:0]     trk_out,
    output lot_pkg::lot_rd_t  rd
);
    import lot_pkg::*;

    localparam int SC_W = $clog2(STAMPS + 1);

    typedef enum logic [1:0] {
        PASS_NONE,
        PASS_SWEEP,
        PASS_FAIL,
        PASS_COUNT
    } pass_t;

    logic            valid_reg, valid_next;
    logic            hit_reg, hit_next;
    logic            free_reg, free_next;
    logic [SC_W-1:0] left_reg, left_next;
    pass_t           pass_reg, pass_next;
    lot_tok_t        tok_reg, tok_next;
    logic [CW-1:0]   act_reg, act_next;
    logic [CW-1:0]   trk_reg, trk_next;

    logic [31:0]     key_reg, key_next;
    logic            isblk_reg, isblk_next;
    logic [31:0]     start_reg, start_next;
    logic [15:0]     len_reg, len_next;
    logic [31:0]     stamp_reg [STAMPS];
    logic [31:0]     stamp_next [STAMPS];
    logic [SC_W-1:0] cnt_reg, cnt_next;
    logic [SC_W-1:0] qcnt_reg, qcnt_next;

    logic            sel;
    logic            active;
    logic            keep;
    logic            wr_keep;
    logic            is_hit;
    logic [31:0]     head;
    logic [SC_W-1:0] cnt_step;

    assign sel    = ctl.use_free ? free_reg : hit_reg;
    assign active = (ctl.clock - start_reg) < {16'd0, len_reg};
    assign head   = stamp_reg[0];
    assign keep   = (ctl.clock - head) <= {16'd0, ctl.window};
    assign is_hit = valid_reg && (key_reg == ctl.key);

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        free_next  = free_reg;
        left_next  = left_reg;
        pass_next  = pass_reg;
        key_next   = key_reg;
        isblk_next = isblk_reg;
        start_next = start_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        qcnt_next  = qcnt_reg;
        wr_keep    = keep || (pass_reg == PASS_COUNT);
        cnt_step   = wr_keep ? cnt_reg : cnt_reg - 1'b1;
        for (int i = 0; i < STAMPS; i++)
        begin
            stamp_next[i] = stamp_reg[i];
        end

        // scan token
        tok_next = tok_in;
        act_next = act_in;
        trk_next = trk_in;
        if (tok_in.run)
        begin
            hit_next            = is_hit;
            free_next           = !valid_reg && !tok_in.free_seen;
            tok_next.free_seen  = tok_in.free_seen | !valid_reg;
            tok_next.match_seen = tok_in.match_seen | is_hit;
            act_next = act_in + CW'(valid_reg && isblk_reg && active);
            trk_next = trk_in + CW'(valid_reg && !isblk_reg);
        end

        // one stamp per cycle: pop head, push back if kept
        if (left_reg != '0)
        begin
            for (int i = 0; i < STAMPS - 1; i++)
            begin
                stamp_next[i] = stamp_reg[i + 1];
            end
            stamp_next[STAMPS-1] = head;
            if (wr_keep)
            begin
                for (int i = 0; i < STAMPS; i++)
                begin
                    if (SC_W'(i + 1) == cnt_reg)
                    begin
                        stamp_next[i] = head;
                    end
                end
            end
            cnt_next  = cnt_step;
            left_next = left_reg - 1'b1;
            if (pass_reg == PASS_COUNT && keep)
            begin
                qcnt_next = qcnt_reg + 1'b1;
            end
            if (left_reg == SC_W'(1))
            begin
                pass_next = PASS_NONE;
                if (pass_reg == PASS_SWEEP && cnt_step == '0)
                begin
                    valid_next = 1'b0;
                end
                if (pass_reg == PASS_FAIL && 5'(cnt_step) >= ctl.limit)
                begin
                    isblk_next = 1'b1;
                    start_next = ctl.clock;
                    len_next   = ctl.length;
                    cnt_next   = '0;
                end
            end
        end

        case (ctl.op)
            OP_SWEEP:
            begin
                if (valid_reg)
                begin
                    if (isblk_reg)
                    begin
                        if (!active)
                        begin
                            valid_next = 1'b0;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        valid_next = 1'b0;
                    end
                    else
                    begin
                        left_next = cnt_reg;
                        pass_next = PASS_SWEEP;
                    end
                end
            end
            OP_FAIL_ADD:
            begin
                if (sel)
                begin
                    pass_next = PASS_FAIL;
                    if (ctl.use_free)
                    begin
                        valid_next    = 1'b1;
                        key_next      = ctl.key;
                        isblk_next    = 1'b0;
                        stamp_next[0] = ctl.clock;
                        cnt_next      = SC_W'(1);
                        left_next     = SC_W'(1);
                    end
                    else if (cnt_reg == SC_W'(STAMPS))
                    begin
                        for (int i = 0; i < STAMPS - 1; i++)
                        begin
                            stamp_next[i] = stamp_reg[i + 1];
                        end
                        stamp_next[STAMPS-1] = ctl.clock;
                        left_next = cnt_reg;
                    end
                    else
                    begin
                        for (int i = 0; i < STAMPS; i++)
                        begin
                            if (SC_W'(i) == cnt_reg)
                            begin
                                stamp_next[i] = ctl.clock;
                            end
                        end
                        cnt_next  = cnt_reg + 1'b1;
                        left_next = cnt_reg + 1'b1;
                    end
                end
            end
            OP_FREE:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                end
            end
            OP_BLOCK:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    key_next   = ctl.key;
                    isblk_next = 1'b1;
                    start_next = ctl.clock;
                    len_next   = ctl.length;
                    cnt_next   = '0;
                end
            end
            OP_COUNT:
            begin
                if (sel)
                begin
                    qcnt_next = '0;
                    left_next = cnt_reg;
                    pass_next = PASS_COUNT;
                end
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
                left_next  = '0;
                pass_next  = PASS_NONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            left_reg  <= '0;
            pass_reg  <= PASS_NONE;
            tok_reg   <= '0;
            act_reg   <= '0;
            trk_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            left_reg  <= left_next;
            pass_reg  <= pass_next;
            tok_reg   <= tok_next;
            act_reg   <= act_next;
            trk_reg   <= trk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        isblk_reg <= isblk_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        cnt_reg   <= cnt_next;
        qcnt_reg  <= qcnt_next;
        for (int i = 0; i < STAMPS; i++)
        begin
            stamp_reg[i] <= stamp_next[i];
        end
    end

    assign tok_out = tok_reg;
    assign act_out = act_reg;
    assign trk_out = trk_reg;

    always_comb
    begin
        rd = '0;
        if (sel)
        begin
            rd.is_block = isblk_reg;
            rd.start    = start_reg;
            rd.len      = len_reg;
            rd.qcnt     = 5'(qcnt_reg);
        end
    end

endmodule

[src/failure_lockout_table.sv]
// ----------------------------------------------------------------------------
// failure lockout table
// per-address failure tracking and blocking over a row of table cells
// ----------------------------------------------------------------------------
// Commands enter on start/command/ip_addr/manual_duration and are taken at a
// clock edge with start high and busy low. Every command gives exactly one
// result beat: done is high for one cycle with the result fields; the
// receiver cannot stall, so a result is never held.
// Tick and clear need no scan: done is registered at the command edge and
// busy stays low. Other commands scan the cell row with a token that moves
// one cell per cycle, through ST_SCAN and ST_SCAN_WAIT until the token
// leaves the last cell, and give the result beat from ST_DECIDE. Query of a
// block adds ST_QBLK, query of a history adds a stamp count pass (ST_QCNT).
// A failure adds the stamp append and prune pass (ST_ADD, ST_FINAL) and,
// once SWEEP_INTERVAL seconds have passed, a table sweep (ST_SWEEP) before
// the scan. Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready; the user must make them only while the block is idle,
// since the block itself does not enforce it.
// Reset clears the clock, the totals and all entries at once.
// ----------------------------------------------------------------------------
`include "failure_lockout_table_assert.svh"

module failure_lockout_table #(
    parameter int TABLE_ENTRIES    = 64,
    parameter int STAMPS_PER_ENTRY = 16,
    parameter int SWEEP_INTERVAL   = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] ip_addr,
    input  logic [15:0] manual_duration,
    output logic        done,
    output logic        blocked,
    output logic [15:0] remaining_seconds,
    output logic [4:0]  window_fails,
    output logic        found,
    output logic        table_full,
    output logic [31:0] block_tally,
    output logic [31:0] fail_tally,
    output logic [6:0]  live_blocks,
    output logic [6:0]  tracked_entries,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lot_pkg::*;

    localparam int CW     = $clog2(TABLE_ENTRIES + 1);
    localparam int WAIT_W = $clog2(STAMPS_PER_ENTRY + 4);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_ADD,
        ST_FINAL,
        ST_QBLK,
        ST_QCNT
    } state_t;

    state_t        state_reg;
    logic [2:0]    cmd_reg;
    logic [31:0]   key_reg;
    logic [15:0]   length_reg;
    logic [4:0]    limit_reg;
    logic [31:0]   clock_reg;
    logic [31:0]   last_sweep_reg;
    logic [31:0]   btot_reg;
    logic [31:0]   ftot_reg;
    lot_op_t       op_reg;
    logic          use_free_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic          match_reg;
    logic          free_reg;
    logic [CW-1:0] act_cap_reg;
    logic [CW-1:0] trk_cap_reg;
    logic [31:0]   age_reg;

    logic          done_reg;
    logic          blocked_reg;
    logic [15:0]   remaining_reg;
    logic [4:0]    fcount_reg;
    logic          found_reg;
    logic          full_reg;
    logic [31:0]   tb_reg;
    logic [31:0]   tf_reg;
    logic [6:0]    ab_reg;
    logic [6:0]    te_reg;

    logic [4:0]    max_failures_reg;
    logic [15:0]   block_duration_reg;
    logic [15:0]   failure_window_reg;

    lot_ctl_t      ctl;
    lot_tok_t      tok [TABLE_ENTRIES + 1];
    logic [CW-1:0] act [TABLE_ENTRIES + 1];
    logic [CW-1:0] trk [TABLE_ENTRIES + 1];
    lot_rd_t       rd_c [TABLE_ENTRIES];
    lot_rd_t       rd;

    assign ctl = '{op: op_reg, use_free: use_free_reg, key: key_reg, clock: clock_reg,
                   window: failure_window_reg, length: length_reg, limit: limit_reg};

    assign tok[0] = '{run: (state_reg == ST_SCAN), free_seen: 1'b0, match_seen: 1'b0};
    assign act[0] = '0;
    assign trk[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        lot_cell #(
            .STAMPS (STAMPS_PER_ENTRY),
            .CW     (CW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (tok[g]),
            .act_in  (act[g]),
            .trk_in  (trk[g]),
            .tok_out (tok[g + 1]),
            .act_out (act[g + 1]),
            .trk_out (trk[g + 1]),
            .rd      (rd_c[g])
        );
    end

    always_comb
    begin
        rd = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            rd = rd | rd_c[i];
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_failures_reg   <= 5'd5;
            block_duration_reg <= 16'd900;
            failure_window_reg <= 16'd300;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_FAILURES:   max_failures_reg   <= cfg_data[4:0];
                CFG_BLOCK_DURATION: block_duration_reg <= cfg_data;
                CFG_FAILURE_WINDOW: failure_window_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_TICK;
            key_reg        <= '0;
            length_reg     <= '0;
            limit_reg      <= '0;
            clock_reg      <= '0;
            last_sweep_reg <= '0;
            btot_reg       <= '0;
            ftot_reg       <= '0;
            op_reg         <= OP_IDLE;
            use_free_reg   <= 1'b0;
            wait_reg       <= '0;
            match_reg      <= 1'b0;
            free_reg       <= 1'b0;
            act_cap_reg    <= '0;
            trk_cap_reg    <= '0;
            age_reg        <= '0;
            done_reg       <= 1'b0;
            blocked_reg    <= 1'b0;
            remaining_reg  <= '0;
            fcount_reg     <= '0;
            found_reg      <= 1'b0;
            full_reg       <= 1'b0;
            tb_reg         <= '0;
            tf_reg         <= '0;
            ab_reg         <= '0;
            te_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            op_reg   <= OP_IDLE;
            case (state_reg)
                ST_IDLE:
                begin
                    use_free_reg <= 1'b0;
                    if (start)
                    begin
                        cmd_reg       <= command;
                        key_reg       <= ip_addr;
                        blocked_reg   <= 1'b0;
                        remaining_reg <= '0;
                        fcount_reg    <= '0;
                        found_reg     <= 1'b0;
                        full_reg      <= 1'b0;
                        tb_reg        <= '0;
                        tf_reg        <= '0;
                        ab_reg        <= '0;
                        te_reg        <= '0;
                        limit_reg     <= (max_failures_reg > 5'(STAMPS_PER_ENTRY)) ?
                                         5'(STAMPS_PER_ENTRY) : max_failures_reg;
                        length_reg    <= (command == CMD_BLOCK && manual_duration != '0) ?
                                         manual_duration : block_duration_reg;
                        case (command)
                            CMD_TICK:
                            begin
                                clock_reg <= clock_reg + 32'd1;
                                done_reg  <= 1'b1;
                            end
                            CMD_CLEAR:
                            begin
                                op_reg   <= OP_CLEAR;
                                btot_reg <= '0;
                                ftot_reg <= '0;
                                done_reg <= 1'b1;
                            end
                            CMD_FAILURE:
                            begin
                                ftot_reg <= ftot_reg + 32'd1;
                                if ((clock_reg - last_sweep_reg) >= 32'(SWEEP_INTERVAL))
                                begin
                                    op_reg         <= OP_SWEEP;
                                    last_sweep_reg <= clock_reg;
                                    wait_reg       <= WAIT_W'(STAMPS_PER_ENTRY + 1);
                                    state_reg      <= ST_SWEEP;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    if (wait_reg == '0)
                    begin
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    state_reg <= ST_SCAN_WAIT;
                end
                ST_SCAN_WAIT:
                begin
                    if (tok[TABLE_ENTRIES].run)
                    begin
                        match_reg   <= tok[TABLE_ENTRIES].match_seen;
                        free_reg    <= tok[TABLE_ENTRIES].free_seen;
                        act_cap_reg <= act[TABLE_ENTRIES];
                        trk_cap_reg <= trk[TABLE_ENTRIES];
                        state_reg   <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                    case (cmd_reg)
                        CMD_FAILURE:
                        begin
                            if (match_reg && rd.is_block)
                            begin
                                blocked_reg <= 1'b1;
                            end
                            else if (!match_reg && !free_reg)
                            begin
                                full_reg <= 1'b1;
                            end
                            else
                            begin
                                op_reg       <= OP_FAIL_ADD;
                                use_free_reg <= !match_reg;
                                wait_reg     <= WAIT_W'(STAMPS_PER_ENTRY + 1);
                                state_reg    <= ST_ADD;
                                done_reg     <= 1'b0;
                            end
                        end
                        CMD_SUCCESS:
                        begin
                            if (match_reg && !rd.is_block)
                            begin
                                op_reg <= OP_FREE;
                            end
                        end
                        CMD_BLOCK:
                        begin
                            if (match_reg || free_reg)
                            begin
                                op_reg       <= OP_BLOCK;
                                use_free_reg <= !match_reg;
                                btot_reg     <= btot_reg + 32'd1;
                            end
                            else
                            begin
                                full_reg <= 1'b1;
                            end
                        end
                        CMD_UNBLOCK:
                        begin
                            if (match_reg && rd.is_block)
                            begin
                                op_reg    <= OP_FREE;
                                found_reg <= 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (match_reg)
                            begin
                                done_reg <= 1'b0;
                                if (rd.is_block)
                                begin
                                    age_reg   <= clock_reg - rd.start;
                                    state_reg <= ST_QBLK;
                                end
                                else
                                begin
                                    op_reg    <= OP_COUNT;
                                    wait_reg  <= WAIT_W'(STAMPS_PER_ENTRY + 1);
                                    state_reg <= ST_QCNT;
                                end
                            end
                        end
                        CMD_STATS:
                        begin
                            tb_reg <= btot_reg;
                            tf_reg <= ftot_reg;
                            ab_reg <= 7'(act_cap_reg);
                            te_reg <= 7'(trk_cap_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_ADD:
                begin
                    if (wait_reg == '0)
                    begin
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - 1'b1;
                    end
                end
                ST_FINAL:
                begin
                    if (rd.is_block)
                    begin
                        blocked_reg <= 1'b1;
                        btot_reg    <= btot_reg + 32'd1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_QBLK:
                begin
                    if (age_reg < {16'd0, rd.len})
                    begin
                        blocked_reg   <= 1'b1;
                        remaining_reg <= rd.len - age_reg[15:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_QCNT:
                begin
                    if (wait_reg == '0)
                    begin
                        fcount_reg <= rd.qcnt;
                        done_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign blocked           = blocked_reg;
    assign remaining_seconds = remaining_reg;
    assign window_fails      = fcount_reg;
    assign found             = found_reg;
    assign table_full        = full_reg;
    assign block_tally       = tb_reg;
    assign fail_tally        = tf_reg;
    assign live_blocks       = ab_reg;
    assign tracked_entries   = te_reg;

    `LOT_ASSERT_IMPL(a_done_src, done, $past(start) || $past(busy))
    `LOT_ASSERT_IMPL(a_tok_exit, tok[TABLE_ENTRIES].run, state_reg == ST_SCAN_WAIT)
    `LOT_ASSERT_IMPL(a_scan_hit, state_reg == ST_SCAN || state_reg == ST_SCAN_WAIT, !use_free_reg)
    `LOT_ASSERT_NEXT(a_clear_tot, start && !busy && command == CMD_CLEAR, btot_reg == '0 && ftot_reg == '0)

endmodule
